[hw/rtl/btk_pkg.sv]
// Package for the binned top-k peak selector: widths, register codes,
// cell commands and controller states. No dependencies.
`default_nettype none

package btk_pkg;

  localparam int MAX_TOP_K = 16;

  localparam int MzW    = 22;
  localparam int IntW   = 32;
  localparam int TopKW  = 5;
  localparam int IdxW   = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;
  localparam int CntW   = $clog2(MAX_TOP_K + 1);
  localparam int StepW  = $clog2(MzW + 1);

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = MzW;

  localparam logic [TopKW-1:0] TOP_K_RST     = TopKW'(5);
  localparam logic [MzW-1:0]   BIN_WIDTH_RST = MzW'(102400);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOP_K     = 1'b0,
    CFG_BIN_WIDTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [MzW-1:0]      mz;
    logic [IntW-1:0]     intensity;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FLUSH_BIN,
    ST_SELECT,
    ST_SCAN,
    ST_CHECK,
    ST_REMOVE,
    ST_INSERT,
    ST_FLUSH_LAST
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/btk_if.sv]
// Valid/ready channel interfaces for peak input and kept-peak output beats.
// Depends on btk_pkg for field widths.
`default_nettype none

interface btk_peak_if import btk_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [MzW-1:0]  peak_mz;
  logic [IntW-1:0] peak_intensity;
  logic            spec_end;

  modport source (output valid, output peak_mz, output peak_intensity, output spec_end,
                  input ready);
  modport sink   (input valid, input peak_mz, input peak_intensity, input spec_end,
                  output ready);
endinterface

interface btk_kept_if import btk_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [MzW-1:0]  kept_mz;
  logic [IntW-1:0] kept_intensity;
  logic            run_end;

  modport source (output valid, output kept_mz, output kept_intensity, output run_end,
                  input ready);
  modport sink   (input valid, input kept_mz, input kept_intensity, input run_end,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/btk_div.sv]
// Radix-2 restoring divider computing the bin index (mz-1)/width, one
// quotient bit per cycle. Depends on btk_pkg.
`default_nettype none

module btk_div import btk_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [MzW-1:0] mz_i,
  input  wire logic [MzW-1:0] width_i,
  output logic                done_o,
  output logic [MzW-1:0]      bin_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [MzW-1:0]   rem_q, rem_d;
  logic [MzW-1:0]   quot_q, quot_d;
  logic [MzW-1:0]   dvsr_q, dvsr_d;
  logic [MzW:0]     shifted;
  logic [MzW+1:0]   diff;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    dvsr_d  = dvsr_q;
    shifted = {rem_q, quot_q[MzW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvsr_q};
    if (start_i) begin
      // m/z zero lands in bin 0
      quot_d = (mz_i == '0) ? '0 : mz_i - MzW'(1);
      rem_d  = '0;
      dvsr_d = (width_i == '0) ? MzW'(1) : width_i;
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      if (!diff[MzW+1]) begin
        rem_d  = diff[MzW-1:0];
        quot_d = {quot_q[MzW-2:0], 1'b1};
      end else begin
        rem_d  = shifted[MzW-1:0];
        quot_d = {quot_q[MzW-2:0], 1'b0};
      end
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(MzW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o = done_q;
  assign bin_o  = quot_q;

endmodule

`default_nettype wire

[hw/rtl/btk_cell.sv]
// One slot of the held-peak row: keeps an m/z and intensity and trades them
// with its neighbors on sorted insert and on remove. Depends on btk_pkg.
`default_nettype none

module btk_cell import btk_pkg::*; (
  input  wire logic            clk_i,
  input  wire cell_ctl_t       ctl_i,
  input  wire logic            occ_i,
  input  wire logic            rm_i,
  input  wire logic            ins_left_i,
  input  wire logic [MzW-1:0]  left_mz_i,
  input  wire logic [IntW-1:0] left_int_i,
  input  wire logic [MzW-1:0]  right_mz_i,
  input  wire logic [IntW-1:0] right_int_i,
  output logic                 ins_o,
  output logic [MzW-1:0]       mz_o,
  output logic [IntW-1:0]      intensity_o
);

  logic [MzW-1:0]  mz_q, mz_d;
  logic [IntW-1:0] int_q, int_d;

  always_comb begin
    // the new peak belongs at or left of this slot
    ins_o = !occ_i || (mz_q > ctl_i.mz);
    mz_d  = mz_q;
    int_d = int_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (ins_left_i) begin
          mz_d  = left_mz_i;
          int_d = left_int_i;
        end else if (ins_o) begin
          mz_d  = ctl_i.mz;
          int_d = ctl_i.intensity;
        end
      end
      CELL_REMOVE: begin
        if (rm_i) begin
          mz_d  = right_mz_i;
          int_d = right_int_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mz_q  <= mz_d;
    int_q <= int_d;
  end

  assign mz_o        = mz_q;
  assign intensity_o = int_q;

endmodule

`default_nettype wire

[hw/rtl/binned_top_k_peak_select.sv]
// Per-bin top-k peak selector: controller, config registers, bin divider and
// the row of btk_cell slots. Depends on btk_pkg, btk_if, btk_div, btk_cell.
// Each peak is binned by the serial divider, then placed in the row; when the
//   bin is full, each held peak is first scanned for the minimum intensity.
// A new peak is taken only in the idle state, after any result beats are sent;
//   the serial divider and the single scan port of the cell row set this.
// Reset: controller, held count, current bin and output valid clear; top_k
//   returns to 5 and bin_width to 102400. Held slots hold no reset value.
`default_nettype none

module binned_top_k_peak_select import btk_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  btk_peak_if.sink                 peak_i,
  btk_kept_if.source               kept_o
);

  state_e            state_q, state_d;
  logic [TopKW-1:0]  top_k_q, top_k_d;
  logic [MzW-1:0]    bin_width_q, bin_width_d;
  logic [MzW-1:0]    mz_q, mz_d;
  logic [IntW-1:0]   int_q, int_d;
  logic              last_q, last_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [MzW-1:0]    cur_bin_q, cur_bin_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   e_q, e_d;
  logic [IntW-1:0]   min_q, min_d;
  logic              kept_valid_q, kept_valid_d;
  logic [MzW-1:0]    kept_mz_q, kept_mz_d;
  logic [IntW-1:0]   kept_int_q, kept_int_d;
  logic              kept_end_q, kept_end_d;

  logic              peak_acc;
  logic              out_free;
  logic [CntW-1:0]   eff_k;
  logic              div_done;
  logic [MzW-1:0]    div_bin;
  cell_ctl_t         cell_ctl;
  logic [IdxW-1:0]   rm_idx;
  logic              last_item;

  logic [MAX_TOP_K-1:0] occ;
  logic [MAX_TOP_K-1:0] rm;
  logic [MAX_TOP_K-1:0] ins;
  logic [MAX_TOP_K-1:0] ins_left;
  logic [MzW-1:0]       cell_mz    [MAX_TOP_K];
  logic [IntW-1:0]      cell_int   [MAX_TOP_K];
  logic [MzW-1:0]       left_mz    [MAX_TOP_K];
  logic [IntW-1:0]      left_int   [MAX_TOP_K];
  logic [MzW-1:0]       right_mz   [MAX_TOP_K];
  logic [IntW-1:0]      right_int  [MAX_TOP_K];

  assign peak_acc = peak_i.valid && peak_i.ready;
  assign out_free = !kept_valid_q || kept_o.ready;

  always_comb begin
    if (top_k_q == '0) begin
      eff_k = CntW'(1);
    end else if (32'(top_k_q) > MAX_TOP_K) begin
      eff_k = CntW'(MAX_TOP_K);
    end else begin
      eff_k = CntW'(top_k_q);
    end
  end

  btk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (peak_acc),
    .mz_i    (peak_i.peak_mz),
    .width_i (bin_width_q),
    .done_o  (div_done),
    .bin_o   (div_bin)
  );

  for (genvar i = 0; i < MAX_TOP_K; i++) begin : g_cell
    assign occ[i] = CntW'(i) < cnt_q;
    assign rm[i]  = IdxW'(i) >= rm_idx;

    if (i == 0) begin : g_first
      assign ins_left[i] = 1'b0;
      assign left_mz[i]  = '0;
      assign left_int[i] = '0;
    end else begin : g_inner_l
      assign ins_left[i] = ins[i-1];
      assign left_mz[i]  = cell_mz[i-1];
      assign left_int[i] = cell_int[i-1];
    end

    if (i == MAX_TOP_K - 1) begin : g_last
      assign right_mz[i]  = '0;
      assign right_int[i] = '0;
    end else begin : g_inner_r
      assign right_mz[i]  = cell_mz[i+1];
      assign right_int[i] = cell_int[i+1];
    end

    btk_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .occ_i       (occ[i]),
      .rm_i        (rm[i]),
      .ins_left_i  (ins_left[i]),
      .left_mz_i   (left_mz[i]),
      .left_int_i  (left_int[i]),
      .right_mz_i  (right_mz[i]),
      .right_int_i (right_int[i]),
      .ins_o       (ins[i]),
      .mz_o        (cell_mz[i]),
      .intensity_o (cell_int[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    top_k_d      = top_k_q;
    bin_width_d  = bin_width_q;
    mz_d         = mz_q;
    int_d        = int_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    cur_bin_d    = cur_bin_q;
    idx_d        = idx_q;
    e_d          = e_q;
    min_d        = min_q;
    kept_valid_d = kept_valid_q && !kept_o.ready;
    kept_mz_d    = kept_mz_q;
    kept_int_d   = kept_int_q;
    kept_end_d   = kept_end_q;
    cell_ctl.op        = CELL_HOLD;
    cell_ctl.mz        = mz_q;
    cell_ctl.intensity = int_q;
    rm_idx       = e_q;
    last_item    = cnt_q == CntW'(1);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOP_K:     top_k_d     = cfg_data_i[TopKW-1:0];
        CFG_BIN_WIDTH: bin_width_d = cfg_data_i[MzW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (peak_acc) begin
          mz_d    = peak_i.peak_mz;
          int_d   = peak_i.peak_intensity;
          last_d  = peak_i.spec_end;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          cur_bin_d = div_bin;
          if (cnt_q != '0 && div_bin != cur_bin_q) begin
            state_d = ST_FLUSH_BIN;
          end else begin
            state_d = ST_SELECT;
          end
        end
      end
      ST_FLUSH_BIN, ST_FLUSH_LAST: begin
        if (out_free) begin
          // emit slot 0 and shift the row down by one
          cell_ctl.op  = CELL_REMOVE;
          rm_idx       = '0;
          cnt_d        = cnt_q - CntW'(1);
          kept_valid_d = 1'b1;
          kept_mz_d    = cell_mz[0];
          kept_int_d   = cell_int[0];
          kept_end_d   = (state_q == ST_FLUSH_LAST) ? last_item : (last_item && !last_q);
          if (last_item) begin
            state_d = (state_q == ST_FLUSH_LAST) ? ST_IDLE : ST_SELECT;
          end
        end
      end
      ST_SELECT: begin
        if (cnt_q < eff_k) begin
          state_d = ST_INSERT;
        end else begin
          idx_d   = '0;
          e_d     = '0;
          min_d   = cell_int[0];
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // keep the latest slot among equal minimums
        if (cell_int[idx_q] <= min_q) begin
          min_d = cell_int[idx_q];
          e_d   = idx_q;
        end
        if (CntW'(idx_q) + CntW'(1) == cnt_q) begin
          state_d = ST_CHECK;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_CHECK: begin
        if (int_q > min_q) begin
          state_d = ST_REMOVE;
        end else if (last_q) begin
          cur_bin_d = '0;
          state_d   = ST_FLUSH_LAST;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REMOVE: begin
        cell_ctl.op = CELL_REMOVE;
        cnt_d       = cnt_q - CntW'(1);
        state_d     = ST_INSERT;
      end
      ST_INSERT: begin
        cell_ctl.op = CELL_INSERT;
        cnt_d       = cnt_q + CntW'(1);
        if (last_q) begin
          cur_bin_d = '0;
          state_d   = ST_FLUSH_LAST;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      top_k_q      <= TOP_K_RST;
      bin_width_q  <= BIN_WIDTH_RST;
      last_q       <= 1'b0;
      cnt_q        <= '0;
      cur_bin_q    <= '0;
      idx_q        <= '0;
      kept_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      top_k_q      <= top_k_d;
      bin_width_q  <= bin_width_d;
      last_q       <= last_d;
      cnt_q        <= cnt_d;
      cur_bin_q    <= cur_bin_d;
      idx_q        <= idx_d;
      kept_valid_q <= kept_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mz_q       <= mz_d;
    int_q      <= int_d;
    e_q        <= e_d;
    min_q      <= min_d;
    kept_mz_q  <= kept_mz_d;
    kept_int_q <= kept_int_d;
    kept_end_q <= kept_end_d;
  end

  assign peak_i.ready          = (state_q == ST_IDLE);
  assign kept_o.valid          = kept_valid_q;
  assign kept_o.kept_mz        = kept_mz_q;
  assign kept_o.kept_intensity = kept_int_q;
  assign kept_o.run_end        = kept_end_q;

endmodule

`default_nettype wire

[hw/rtl/btk_checker.sv]
// Port-level checks for the binned top-k peak selector, bound to the top.
// Depends on btk_pkg and binned_top_k_peak_select.
`default_nettype none

module btk_checker import btk_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            peak_valid_i,
  input wire logic            peak_ready_i,
  input wire logic            kept_valid_i,
  input wire logic            kept_ready_i,
  input wire logic [MzW-1:0]  kept_mz_i,
  input wire logic [IntW-1:0] kept_intensity_i,
  input wire logic            kept_run_end_i
);

  a_kept_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_valid_i && !kept_ready_i |=> kept_valid_i)
    else $error("kept beat dropped while stalled");

  a_kept_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_valid_i && !kept_ready_i |=>
      $stable(kept_mz_i) && $stable(kept_intensity_i) && $stable(kept_run_end_i))
    else $error("kept payload changed while stalled");

  a_peak_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_valid_i && peak_ready_i |=> !peak_ready_i ##1 !peak_ready_i)
    else $error("peak taken while the previous one is still being binned");

  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_valid_i && !kept_run_end_i |-> !peak_ready_i)
    else $error("new peak offered before all results of the previous one");

endmodule

bind binned_top_k_peak_select btk_checker u_btk_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .peak_valid_i     (peak_i.valid),
  .peak_ready_i     (peak_i.ready),
  .kept_valid_i     (kept_o.valid),
  .kept_ready_i     (kept_o.ready),
  .kept_mz_i        (kept_o.kept_mz),
  .kept_intensity_i (kept_o.kept_intensity),
  .kept_run_end_i   (kept_o.run_end)
);

`default_nettype wire
